### sv/sha256_sh_pkg.sv
// Package: SHA-256 round constants, initial hash values and sequencer states.
`default_nettype none
package sha256_sh_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned NumRounds = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k_table [0:63];
      k_table = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k_table[idx];
   endfunction

   function automatic logic [31:0] initial_h(input logic [2:0] idx);
      logic [31:0] h_table [0:7];
      h_table = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                  32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h_table[idx];
   endfunction

endpackage
`default_nettype wire

### sv/sha256_stream_hasher.sv
// Top level: streaming SHA-256 hasher with one shared round unit.
// Sequence: a request is taken in idle, then its bytes are absorbed one at a time;
// each full block adds a load step, the round steps and a final-add step.
// A last request adds a pad step and one block pass per padding block (1 or 2), then 8 digest words.
// A new request is accepted only in idle, once the previous one is fully processed.
// Reset (synchronous) restores initial hash values, clears fill and bit count.
`default_nettype none
module sha256_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_bytes_valid,
   input  wire logic        req_last_item,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   import sha256_sh_pkg::*;

   state_type state_ff, state_in;
   logic [31:0] hash_ff [0:7];
   logic [31:0] win_ff [0:15];
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [31:0] data_ff;
   logic [2:0]  cnt_ff;
   logic        last_ff;
   logic        padded_ff;
   logic        lenblk_ff;
   logic [5:0]  round_ff;
   logic [2:0]  emit_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;

   logic [2:0]  nbytes;
   logic [31:0] w_cur, w15, w2, s0, s1, t1, t2, w_new;
   logic        blk_full;
   logic        len_fits;
   logic [4:0]  lane_lsb;

   assign nbytes = (req_bytes_valid > 3'd4) ? 3'd4 : req_bytes_valid;
   assign w15 = win_ff[1];
   assign w2  = win_ff[14];
   assign s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
   assign s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
   assign w_new = win_ff[0] + s0 + win_ff[9] + s1;
   assign w_cur = win_ff[0];
   assign t1 = h_ff + ({e_ff[5:0], e_ff[31:6]} ^ {e_ff[10:0], e_ff[31:11]}
               ^ {e_ff[24:0], e_ff[31:25]}) + ((e_ff & f_ff) ^ (~e_ff & g_ff))
               + round_k(round_ff) + w_cur;
   assign t2 = ({a_ff[1:0], a_ff[31:2]} ^ {a_ff[12:0], a_ff[31:13]}
               ^ {a_ff[21:0], a_ff[31:22]}) + ((a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff));
   assign blk_full = (fill_ff == 6'd63);
   assign len_fits = padded_ff || (fill_ff < 6'd56);
   assign lane_lsb = 5'd24 - {fill_ff[1:0], 3'd0};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_ABSORB;
         ST_ABSORB: begin
            if (cnt_ff != 3'd0 && blk_full) state_in = ST_LOAD;
            else if (cnt_ff == 3'd0 || (cnt_ff == 3'd1 && !blk_full))
               state_in = (cnt_ff == 3'd0 && last_ff) ? ST_PAD :
                          (cnt_ff == 3'd0) ? ST_IDLE : (last_ff ? ST_PAD : ST_IDLE);
         end
         ST_PAD: state_in = ST_LOAD;
         ST_LOAD: state_in = ST_ROUND;
         ST_ROUND: if (round_ff == 6'd63) state_in = ST_FINAL;
         ST_FINAL: begin
            if (cnt_ff != 3'd0) state_in = ST_ABSORB;
            else if (!last_ff) state_in = ST_IDLE;
            else if (!lenblk_ff) state_in = ST_PAD;
            else state_in = ST_EMIT;
         end
         ST_EMIT: if (rsp_ready && emit_ff == 3'd7) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      rsp_digest_word = hash_ff[emit_ff];
      rsp_word_index = emit_ff;
      rsp_last_word = (emit_ff == 3'd7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         bits_ff <= '0;
         cnt_ff <= '0;
         last_ff <= 1'b0;
         padded_ff <= 1'b0;
         lenblk_ff <= 1'b0;
         round_ff <= '0;
         emit_ff <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= initial_h(3'(i));
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               data_ff <= req_data_word;
               cnt_ff <= nbytes;
               last_ff <= req_last_item;
               padded_ff <= 1'b0;
               lenblk_ff <= 1'b0;
               bits_ff <= bits_ff + {58'd0, nbytes, 3'd0};
            end
            ST_ABSORB: if (cnt_ff != 3'd0) begin
               win_ff[fill_ff[5:2]][lane_lsb +: 8] <= data_ff[31:24];
               data_ff <= {data_ff[23:0], 8'd0};
               cnt_ff <= cnt_ff - 3'd1;
               fill_ff <= fill_ff + 6'd1;
            end
            ST_PAD: begin
               for (int i = 0; i < 16; i++) begin
                  if (len_fits && i == 14) win_ff[i] <= bits_ff[63:32];
                  else if (len_fits && i == 15) win_ff[i] <= bits_ff[31:0];
                  else begin
                     for (int j = 0; j < 4; j++) begin
                        if (6'(4*i + j) == fill_ff && !padded_ff)
                           win_ff[i][31 - 8*j -: 8] <= 8'h80;
                        else if (6'(4*i + j) > fill_ff || padded_ff)
                           win_ff[i][31 - 8*j -: 8] <= 8'h00;
                     end
                  end
               end
               padded_ff <= 1'b1;
               if (len_fits) lenblk_ff <= 1'b1;
               fill_ff <= '0;
            end
            ST_LOAD: begin
               a_ff <= hash_ff[0]; b_ff <= hash_ff[1]; c_ff <= hash_ff[2]; d_ff <= hash_ff[3];
               e_ff <= hash_ff[4]; f_ff <= hash_ff[5]; g_ff <= hash_ff[6]; h_ff <= hash_ff[7];
               round_ff <= '0;
            end
            ST_ROUND: begin
               for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
               win_ff[15] <= w_new;
               h_ff <= g_ff; g_ff <= f_ff; f_ff <= e_ff; e_ff <= d_ff + t1;
               d_ff <= c_ff; c_ff <= b_ff; b_ff <= a_ff; a_ff <= t1 + t2;
               round_ff <= round_ff + 6'd1;
            end
            ST_FINAL: begin
               hash_ff[0] <= hash_ff[0] + a_ff; hash_ff[1] <= hash_ff[1] + b_ff;
               hash_ff[2] <= hash_ff[2] + c_ff; hash_ff[3] <= hash_ff[3] + d_ff;
               hash_ff[4] <= hash_ff[4] + e_ff; hash_ff[5] <= hash_ff[5] + f_ff;
               hash_ff[6] <= hash_ff[6] + g_ff; hash_ff[7] <= hash_ff[7] + h_ff;
               emit_ff <= '0;
            end
            ST_EMIT: if (rsp_ready) begin
               emit_ff <= emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) hash_ff[i] <= initial_h(3'(i));
                  bits_ff <= '0;
                  fill_ff <= '0;
                  last_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire
